### design/clbsc_pkg.sv
package clbsc_pkg;

	localparam int unsigned SEED_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// Slots in the queue between front and back (one-bit pointers, two-bit count)
	localparam int unsigned Q_DEPTH = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_C = 2'd2;

	// Default seeds, also the reset values
	localparam logic [SEED_W-1:0] DEF_A = 32'h1357_9bdf;
	localparam logic [SEED_W-1:0] DEF_B = 32'h2468_ace0;
	localparam logic [SEED_W-1:0] DEF_C = 32'hfdb9_7531;

	// Step constants per register: tap mask, fill for the set case, keep mask
	localparam logic [SEED_W-1:0] TAP_A  = 32'h8000_0062;
	localparam logic [SEED_W-1:0] ONES_A = 32'h8000_0000;
	localparam logic [SEED_W-1:0] KEEP_A = 32'h7fff_ffff;
	localparam logic [SEED_W-1:0] TAP_B  = 32'h4000_0020;
	localparam logic [SEED_W-1:0] ONES_B = 32'hc000_0000;
	localparam logic [SEED_W-1:0] KEEP_B = 32'h3fff_ffff;
	localparam logic [SEED_W-1:0] TAP_C  = 32'h1000_0002;
	localparam logic [SEED_W-1:0] ONES_C = 32'hf000_0000;
	localparam logic [SEED_W-1:0] KEEP_C = 32'h0fff_ffff;

	// One byte job in the queue between front and back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              restart;
	} item_t;

	// The three shift registers (or the three seeds)
	typedef struct packed {
		logic [SEED_W-1:0] a;
		logic [SEED_W-1:0] b;
		logic [SEED_W-1:0] c;
	} lfsr_t;

	typedef struct packed {
		lfsr_t             nxt;
		logic [BYTE_W-1:0] ks;
	} ks_res_t;

	function automatic logic [SEED_W-1:0] lfsr_step(
		input logic [SEED_W-1:0] r,
		input logic [SEED_W-1:0] tap,
		input logic [SEED_W-1:0] ones,
		input logic [SEED_W-1:0] keep
	);
		logic [SEED_W-1:0] res;
		if (r[0]) begin
			res = ((r ^ tap) >> 1) | ones;
		end else begin
			res = (r >> 1) & keep;
		end
		return res;
	endfunction

	// Eight clocked steps, first keystream bit lands in the MSB
	function automatic ks_res_t ks_byte(input lfsr_t s);
		ks_res_t           res;
		logic [SEED_W-1:0] a;
		logic [SEED_W-1:0] b;
		logic [SEED_W-1:0] c;
		logic              ob;
		logic              oc;
		logic              sel;
		logic [BYTE_W-1:0] ks;
		a  = s.a;
		b  = s.b;
		c  = s.c;
		ob = b[0];
		oc = c[0];
		ks = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			sel = a[0];
			a   = lfsr_step(a, TAP_A, ONES_A, KEEP_A);
			if (sel) begin
				ob = b[0];
				b  = lfsr_step(b, TAP_B, ONES_B, KEEP_B);
			end else begin
				oc = c[0];
				c  = lfsr_step(c, TAP_C, ONES_C, KEEP_C);
			end
			ks = {ks[BYTE_W-2:0], ob ^ oc};
		end
		res.nxt.a = a;
		res.nxt.b = b;
		res.nxt.c = c;
		res.ks    = ks;
		return res;
	endfunction

endpackage

### design/clbsc_front.sv
module clbsc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [clbsc_pkg::BYTE_W-1:0]      data_in,
	input  logic                              restart,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [clbsc_pkg::SEED_W-1:0]      cfg_data,
	output clbsc_pkg::lfsr_t                  seeds,
	input  logic                              q_full,
	output logic                              q_push,
	output clbsc_pkg::item_t                  q_item
);

	clbsc_pkg::lfsr_t seed_q;

	// zero seed swapped for its default when written, so a restart loads directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q.a <= clbsc_pkg::DEF_A;
			seed_q.b <= clbsc_pkg::DEF_B;
			seed_q.c <= clbsc_pkg::DEF_C;
		end else if (cfg_valid) begin
			case (cfg_index)
				clbsc_pkg::CFG_SEED_A: begin
					seed_q.a <= (cfg_data == '0) ? clbsc_pkg::DEF_A : cfg_data;
				end
				clbsc_pkg::CFG_SEED_B: begin
					seed_q.b <= (cfg_data == '0) ? clbsc_pkg::DEF_B : cfg_data;
				end
				clbsc_pkg::CFG_SEED_C: begin
					seed_q.c <= (cfg_data == '0) ? clbsc_pkg::DEF_C : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready      = 1'b1;
	assign seeds          = seed_q;
	assign in_ready       = !q_full;
	assign q_push         = in_valid && !q_full;
	assign q_item.data    = data_in;
	assign q_item.restart = restart;

endmodule

### design/clbsc_queue.sv
module clbsc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clbsc_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output clbsc_pkg::item_t head
);

	clbsc_pkg::item_t slot_q [clbsc_pkg::Q_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'(clbsc_pkg::Q_DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/clbsc_back.sv
module clbsc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  clbsc_pkg::lfsr_t             seeds,
	input  logic                         q_not_empty,
	input  clbsc_pkg::item_t             q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [clbsc_pkg::BYTE_W-1:0] data_out
);

	clbsc_pkg::lfsr_t              lfsr_q;
	clbsc_pkg::lfsr_t              start;
	clbsc_pkg::ks_res_t            res;
	logic                          out_valid_q;
	logic [clbsc_pkg::BYTE_W-1:0]  data_out_q;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);
	assign start = q_head.restart ? seeds : lfsr_q;
	assign res   = clbsc_pkg::ks_byte(start);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q.a    <= clbsc_pkg::DEF_A;
			lfsr_q.b    <= clbsc_pkg::DEF_B;
			lfsr_q.c    <= clbsc_pkg::DEF_C;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				lfsr_q      <= res.nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_out_q <= q_head.data ^ res.ks;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

endmodule

### design/clocked_lfsr_byte_stream_cipher_core.sv
// Channel  | handshake             | payload
// ---------+-----------------------+----------------------------------
// in       | in_valid / in_ready   | data_in[7:0], restart
// out      | out_valid / out_ready | data_out[7:0]
// cfg      | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// One byte per clock sustained while out_ready stays high. A beat sits in a queue
// slot after acceptance and, once the output register is free, is popped through the
// eight-step keystream unit into the output register, which drives data_out.
// Reset (arst_n low) loads the default seeds and shift registers and empties the queue.
// The front keeps taking beats while the queue has room, so a stall on out backs up
// through the two-slot queue before in_ready drops. cfg_ready is always high.
module clocked_lfsr_byte_stream_cipher_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [clbsc_pkg::BYTE_W-1:0]      data_in,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [clbsc_pkg::BYTE_W-1:0]      data_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [clbsc_pkg::SEED_W-1:0]      cfg_data
);

	clbsc_pkg::lfsr_t seeds;
	clbsc_pkg::item_t push_item;
	clbsc_pkg::item_t head;
	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;

	// Front: seed registers (zero seed mapped to default on write) and input accept
	clbsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_in   (data_in),
		.restart   (restart),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seeds     (seeds),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// Two-slot queue decouples the input side from output back-pressure
	clbsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// Back: keystream byte from the three shift registers, XOR, output register
	clbsc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seeds       (seeds),
		.q_not_empty (q_not_empty),
		.q_head      (head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_out    (data_out)
	);

endmodule
